>>> rtl/lpfc_pkg.sv
`default_nettype none

package lpfc_pkg;

  localparam int COUNT_W = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Registered item heading into the frame set and the totals
  typedef struct packed {
    logic valid;
    logic clear;
  } req_t;

  // Lookup outcome for one item
  typedef struct packed {
    logic hit;
    logic evicted;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/lpfc_frame_set.sv
`default_nettype none

module lpfc_frame_set #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16,
  localparam int FIDX_W   = $clog2(FRAMES)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lpfc_pkg::req_t        req,
  input  wire logic [PAGE_BITS-1:0]  page,
  output lpfc_pkg::status_t          status,
  output logic [FIDX_W-1:0]          frame,
  output logic [PAGE_BITS-1:0]       evicted_page
);

  localparam logic [FIDX_W-1:0] RANK_MAX = FIDX_W'(FRAMES - 1);

  logic [PAGE_BITS-1:0] tag_r  [FRAMES];
  logic [FIDX_W-1:0]    rank_r [FRAMES];
  logic [FIDX_W-1:0]    rank_nxt [FRAMES];
  logic [FRAMES-1:0]    valid_r;
  logic [FRAMES-1:0]    valid_nxt;

  logic              hit_any;
  logic              empty_any;
  logic [FIDX_W-1:0] hit_idx;
  logic [FIDX_W-1:0] empty_idx;
  logic [FIDX_W-1:0] victim_idx;
  logic [FIDX_W-1:0] frame_sel;
  logic [FIDX_W-1:0] rank_sel;
  logic              age;
  logic              do_access;

  assign do_access = req.valid && !req.clear;

  always_comb begin
    hit_any    = 1'b0;
    empty_any  = 1'b0;
    hit_idx    = '0;
    empty_idx  = '0;
    victim_idx = '0;
    // scan downward so the lowest-numbered frame wins
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == page) begin
        hit_any = 1'b1;
        hit_idx = FIDX_W'(i);
      end
      if (!valid_r[i]) begin
        empty_any = 1'b1;
        empty_idx = FIDX_W'(i);
      end
      // with all frames valid the ranks are a permutation, so the oldest holds RANK_MAX
      if (rank_r[i] == RANK_MAX) begin
        victim_idx = FIDX_W'(i);
      end
    end

    if (hit_any) begin
      frame_sel = hit_idx;
    end else if (empty_any) begin
      frame_sel = empty_idx;
    end else begin
      frame_sel = victim_idx;
    end
    rank_sel = rank_r[frame_sel];

    valid_nxt = valid_r;
    valid_nxt[frame_sel] = 1'b1;

    for (int i = 0; i < FRAMES; i++) begin
      age = (FIDX_W'(i) != frame_sel) && valid_r[i] &&
            (!hit_any || rank_r[i] < rank_sel) && (rank_r[i] != RANK_MAX);
      rank_nxt[i] = age ? rank_r[i] + 1'b1 : rank_r[i];
      if (FIDX_W'(i) == frame_sel) begin
        rank_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '{default: '0};
    end else if (req.valid) begin
      if (req.clear) begin
        valid_r <= '0;
        rank_r  <= '{default: '0};
      end else begin
        valid_r <= valid_nxt;
        rank_r  <= rank_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_access && !hit_any) begin
      tag_r[frame_sel] <= page;
    end
  end

  always_comb begin
    status.hit     = !req.clear && hit_any;
    status.evicted = !req.clear && !hit_any && !empty_any;
    frame          = req.clear ? '0 : frame_sel;
    evicted_page   = status.evicted ? tag_r[victim_idx] : '0;
  end

`ifndef SYNTH
  a_evict_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid && status.evicted |-> &valid_r)
    else $error("eviction while an empty frame exists");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    do_access |-> !(status.hit && status.evicted))
    else $error("hit and eviction on the same item");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid && req.clear |=> valid_r == '0)
    else $error("frames still valid after clear");

  a_used_is_newest: assert property (@(posedge clk) disable iff (!rst_n)
    do_access |=> valid_r[$past(frame_sel)] && rank_r[$past(frame_sel)] == '0)
    else $error("used frame not valid and most recent");
`endif

endmodule

`default_nettype wire

>>> rtl/lpfc_totals.sv
`default_nettype none

module lpfc_totals (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lpfc_pkg::req_t                req,
  input  wire logic                          hit,
  output logic [lpfc_pkg::COUNT_W-1:0]       hit_total_r,
  output logic [lpfc_pkg::COUNT_W-1:0]       miss_total_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r  <= '0;
      miss_total_r <= '0;
    end else if (req.valid) begin
      if (req.clear) begin
        hit_total_r  <= '0;
        miss_total_r <= '0;
      end else if (hit) begin
        // saturate at the top
        if (hit_total_r != lpfc_pkg::COUNT_MAX) begin
          hit_total_r <= hit_total_r + 1'b1;
        end
      end else if (miss_total_r != lpfc_pkg::COUNT_MAX) begin
        miss_total_r <= miss_total_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lru_page_frame_cache.sv
// Channel   Handshake            Fields
// input     start & !busy        in_command, in_page_number
// result    out_valid (strobe)   out_hit, out_frame_used, out_evicted_valid,
//                                out_evicted_page, out_hit_count, out_miss_count
//
// One item per cycle while busy is low; the result strobes once the item has passed the input register,
// then one pass of tag compare and rank update into the result register.
// The per-frame tag compare, victim pick and rank update are all combinational between those two registers.
// busy is high only during reset and the cycle after it; it never rises otherwise.
// Synchronous active-low reset empties all frames and zeroes both totals.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module lru_page_frame_cache #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16,
  localparam int FIDX_W   = $clog2(FRAMES)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_command,
  input  wire logic [PAGE_BITS-1:0]          in_page_number,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [FIDX_W-1:0]                  out_frame_used,
  output logic                               out_evicted_valid,
  output logic [PAGE_BITS-1:0]               out_evicted_page,
  output logic [lpfc_pkg::COUNT_W-1:0]       out_hit_count,
  output logic [lpfc_pkg::COUNT_W-1:0]       out_miss_count
);

  logic                 busy_r;
  logic                 in_valid_r;
  logic                 cmd_r;
  logic [PAGE_BITS-1:0] page_r;
  lpfc_pkg::req_t       req;
  lpfc_pkg::status_t    status;
  logic [FIDX_W-1:0]    frame;
  logic [PAGE_BITS-1:0] evicted_page;

  logic                 out_valid_r;
  logic                 hit_r;
  logic [FIDX_W-1:0]    frame_r;
  logic                 ev_valid_r;
  logic [PAGE_BITS-1:0] ev_page_r;

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      in_valid_r  <= start && !busy_r;
      out_valid_r <= in_valid_r;
    end
  end

  // payload stages carry no reset
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      cmd_r  <= in_command;
      page_r <= in_page_number;
    end
    if (in_valid_r) begin
      hit_r      <= status.hit;
      frame_r    <= frame;
      ev_valid_r <= status.evicted;
      ev_page_r  <= evicted_page;
    end
  end

  assign req.valid = in_valid_r;
  assign req.clear = (cmd_r == lpfc_pkg::CMD_CLEAR);

  lpfc_frame_set #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_frame_set (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .page         (page_r),
    .status       (status),
    .frame        (frame),
    .evicted_page (evicted_page)
  );

  lpfc_totals u_totals (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .hit          (status.hit),
    .hit_total_r  (out_hit_count),
    .miss_total_r (out_miss_count)
  );

  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_frame_used    = frame_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = ev_page_r;

endmodule

`default_nettype wire
